// ----- rtl/core/sqrb_pkg.sv -----
// ----------------------------------------------------------------------------
// sqrb_pkg
// Shared types and constants for the sequence reorder buffer.
// ----------------------------------------------------------------------------
package sqrb_pkg;

    localparam int SEQ_W       = 32;
    localparam int PAY_W       = 32;
    localparam int NOW_W       = 32;
    localparam int WS_W        = 6;
    localparam int SKIP_W      = 6;
    localparam int RESULTS_MAX = 32;
    localparam int CNT_W       = 6;
    localparam int BIT_CNT_W   = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [WS_W-1:0]  WS_RESET       = 6'd32;
    localparam logic [NOW_W-1:0] MAX_WAIT_RESET = 32'd500;

    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_TIMEOUT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE = 2'd0,
        REG_MAX_WAIT    = 2'd1
    } reg_idx_t;

    typedef enum logic [2:0] {
        KIND_RELEASED   = 3'd0,
        KIND_BUFFERED   = 3'd1,
        KIND_LATE       = 3'd2,
        KIND_DUPLICATE  = 3'd3,
        KIND_DROP       = 3'd4,
        KIND_NO_TIMEOUT = 3'd5,
        KIND_SKIPPED    = 3'd6
    } kind_t;

    typedef struct packed {
        logic             action;
        logic [SEQ_W-1:0] seq;
        logic [PAY_W-1:0] payload;
        logic [NOW_W-1:0] now;
    } in_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [SEQ_W-1:0]  out_seq;
        logic [PAY_W-1:0]  out_payload;
        logic [SKIP_W-1:0] skipped;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic wr;
        logic clr;
    } slot_cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_DECIDE,
        S_BUF_RD,
        S_BUF_CHK,
        S_SKIP_RD,
        S_SKIP_CHK,
        S_DRAIN_RD,
        S_DRAIN_CHK
    } state_t;

endpackage

// ----- rtl/core/sqrb_rem_unit.sv -----
// ----------------------------------------------------------------------------
// sqrb_rem_unit
// Bit-serial remainder of a 32-bit value by the window size, one bit a cycle.
// ----------------------------------------------------------------------------
module sqrb_rem_unit #(
    parameter int WINDOW_MAX = 32
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             start,
    input  logic [sqrb_pkg::SEQ_W-1:0]                       value,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]                  divisor,
    output logic                                             done,
    output logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] rem
);

    localparam int WW = $clog2(WINDOW_MAX + 1);
    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [sqrb_pkg::SEQ_W-1:0]     sh_reg, sh_next;
    logic [WW-1:0]                  rem_reg, rem_next;
    logic [sqrb_pkg::BIT_CNT_W-1:0] bits_reg, bits_next;
    logic [WW:0]                    trial;
    logic [WW:0]                    div_ext;

    assign trial   = {rem_reg, sh_reg[sqrb_pkg::SEQ_W-1]};
    assign div_ext = {1'b0, divisor};

    always_comb
    begin
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        bits_next = bits_reg;
        if (start)
        begin
            sh_next   = value;
            rem_next  = '0;
            bits_next = sqrb_pkg::BIT_CNT_W'(sqrb_pkg::SEQ_W);
        end
        else if (bits_reg != '0)
        begin
            sh_next   = {sh_reg[sqrb_pkg::SEQ_W-2:0], 1'b0};
            rem_next  = (trial >= div_ext) ? WW'(trial - div_ext) : WW'(trial);
            bits_next = bits_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
        end
        else
        begin
            bits_reg <= bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign done = (bits_reg == '0);
    assign rem  = rem_reg[IW-1:0];

endmodule

// ----- rtl/core/sqrb_slot_store.sv -----
// ----------------------------------------------------------------------------
// sqrb_slot_store
// Slot memory (sequence number and payload) with per-slot valid flops.
// ----------------------------------------------------------------------------
module sqrb_slot_store #(
    parameter int WINDOW_MAX = 32,
    parameter int PAYLOAD_W  = 32
) (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0]  rd_addr,
    output logic                                                    rd_valid,
    output logic [sqrb_pkg::SEQ_W-1:0]                              rd_seq,
    output logic [PAYLOAD_W-1:0]                                    rd_payload,
    input  sqrb_pkg::slot_cmd_t                                     cmd,
    input  logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0]  wr_addr,
    input  logic [sqrb_pkg::SEQ_W-1:0]                              wr_seq,
    input  logic [PAYLOAD_W-1:0]                                    wr_payload
);

    logic [WINDOW_MAX-1:0]      valid_reg, valid_next;
    logic                       rd_valid_reg;
    logic [sqrb_pkg::SEQ_W-1:0] seq_mem [WINDOW_MAX];
    logic [PAYLOAD_W-1:0]       pay_mem [WINDOW_MAX];
    logic [sqrb_pkg::SEQ_W-1:0] rd_seq_reg;
    logic [PAYLOAD_W-1:0]       rd_payload_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.wr)
        begin
            valid_next[wr_addr] = 1'b1;
        end
        if (cmd.clr)
        begin
            valid_next[wr_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            seq_mem[wr_addr] <= wr_seq;
            pay_mem[wr_addr] <= wr_payload;
        end
        rd_seq_reg     <= seq_mem[rd_addr];
        rd_payload_reg <= pay_mem[rd_addr];
    end

    assign rd_valid   = rd_valid_reg;
    assign rd_seq     = rd_seq_reg;
    assign rd_payload = rd_payload_reg;

endmodule

// ----- rtl/core/sequence_reorder_buffer.sv -----
// Path: item register, serial seq mod window remainder, decide state, output
//   register; a buffered packet and each released packet add a slot read and check.
// Items: one at a time, none taken until the last result is registered; the pace is
//   set by the bit-serial seq mod window unit and the single slot memory read port.
// Reset: control cleared at once, valid flops cleared, no clearing pass;
//   expected number 1, window_size 32, max_wait 500.
// ----------------------------------------------------------------------------
// sequence_reorder_buffer
// Sliding-window reorder buffer with gap timer and timeout skip.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer #(
    parameter int WINDOW_MAX = 32,
    parameter int PAYLOAD_W  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  sqrb_pkg::in_item_t                  item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output sqrb_pkg::out_item_t                 result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sqrb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sqrb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int WW = $clog2(WINDOW_MAX + 1);
    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = (WW > sqrb_pkg::WS_W) ? WW : sqrb_pkg::WS_W;

    sqrb_pkg::state_t            state_reg, state_next;
    sqrb_pkg::in_item_t          item_reg, item_next;
    logic [sqrb_pkg::SEQ_W-1:0]  exp_reg, exp_next;
    logic [IW-1:0]               exp_mod_reg, exp_mod_next;
    logic [sqrb_pkg::SEQ_W-1:0]  highest_reg, highest_next;
    logic                        gap_open_reg, gap_open_next;
    logic [sqrb_pkg::NOW_W-1:0]  gap_start_reg, gap_start_next;
    logic [sqrb_pkg::WS_W-1:0]   ws_reg, ws_next;
    logic [sqrb_pkg::NOW_W-1:0]  max_wait_reg, max_wait_next;
    logic [WW-1:0]               skp_reg, skp_next;
    logic [sqrb_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    sqrb_pkg::out_item_t         pend_reg, pend_next;
    logic                        result_valid_reg, result_valid_next;
    sqrb_pkg::out_item_t         result_reg, result_next;

    logic [WW-1:0]               win;
    logic                        accept;
    logic                        mod_start;
    logic                        seq_done;
    logic                        exp_done;
    logic [IW-1:0]               seq_rem;
    logic [IW-1:0]               exp_rem;
    logic [IW-1:0]               rd_addr;
    logic                        rd_valid;
    logic [sqrb_pkg::SEQ_W-1:0]  rd_seq;
    logic [PAYLOAD_W-1:0]        rd_payload;
    sqrb_pkg::slot_cmd_t         slot_cmd;
    logic [IW-1:0]               slot_addr;
    logic [PAYLOAD_W-1:0]        pay_store;
    logic [sqrb_pkg::PAY_W-1:0]  pay_m;
    logic [WW-1:0]               exp_mod_nx;
    logic [IW-1:0]               exp_mod_inc;
    logic                        out_free;
    logic                        is_late;
    logic                        is_eq;
    logic                        is_drop;
    logic                        fire;
    logic                        skip_go;
    logic                        hit_seq;
    logic                        hit_exp;
    logic                        cnt_full;
    logic                        drain_more;

    function automatic sqrb_pkg::out_item_t mk_result(
        input sqrb_pkg::kind_t              k,
        input logic [sqrb_pkg::SEQ_W-1:0]   sq,
        input logic [sqrb_pkg::PAY_W-1:0]   pay,
        input logic [sqrb_pkg::SKIP_W-1:0]  skp,
        input logic                         lst
    );
        sqrb_pkg::out_item_t r;
        r.kind        = k;
        r.out_seq     = sq;
        r.out_payload = pay;
        r.skipped     = skp;
        r.last        = lst;
        return r;
    endfunction

    // effective window: 0 or oversize means the built window
    assign win = ((ws_reg == '0) || (CW'(ws_reg) > CW'(WINDOW_MAX)))
               ? WW'(WINDOW_MAX) : WW'(ws_reg);

    assign accept    = (state_reg == sqrb_pkg::S_IDLE) && item_valid;
    assign mod_start = accept;

    sqrb_rem_unit #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_seq_rem (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .value   (item.seq),
        .divisor (win),
        .done    (seq_done),
        .rem     (seq_rem)
    );

    sqrb_rem_unit #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_exp_rem (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .value   (exp_reg),
        .divisor (win),
        .done    (exp_done),
        .rem     (exp_rem)
    );

    always_comb
    begin
        case (state_reg)
            sqrb_pkg::S_BUF_RD, sqrb_pkg::S_BUF_CHK: rd_addr = seq_rem;
            default:                                 rd_addr = exp_mod_reg;
        endcase
    end

    sqrb_slot_store #(
        .WINDOW_MAX (WINDOW_MAX),
        .PAYLOAD_W  (PAYLOAD_W)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_addr    (rd_addr),
        .rd_valid   (rd_valid),
        .rd_seq     (rd_seq),
        .rd_payload (rd_payload),
        .cmd        (slot_cmd),
        .wr_addr    (slot_addr),
        .wr_seq     (item_reg.seq),
        .wr_payload (pay_store)
    );

    assign pay_store = PAYLOAD_W'(item_reg.payload);
    assign pay_m     = sqrb_pkg::PAY_W'(pay_store);

    assign exp_mod_nx  = WW'(exp_mod_reg) + WW'(1);
    assign exp_mod_inc = ((exp_reg == '1) || (exp_mod_nx == win)) ? '0 : exp_mod_nx[IW-1:0];

    assign out_free   = !result_valid_reg || !result_stall;
    assign is_late    = item_reg.seq < exp_reg;
    assign is_eq      = item_reg.seq == exp_reg;
    assign is_drop    = {1'b0, item_reg.seq} >
                        ({1'b0, exp_reg} + (sqrb_pkg::SEQ_W+1)'(win) - 33'd1);
    assign fire       = gap_open_reg && ((item_reg.now - gap_start_reg) >= max_wait_reg);
    assign skip_go    = (exp_reg <= highest_reg) && (skp_reg < WW'(WINDOW_MAX));
    assign hit_seq    = rd_valid && (rd_seq == item_reg.seq);
    assign hit_exp    = rd_valid && (rd_seq == exp_reg);
    assign cnt_full   = cnt_reg == sqrb_pkg::CNT_W'(sqrb_pkg::RESULTS_MAX);
    assign drain_more = hit_exp && !cnt_full;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sqrb_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = sqrb_pkg::S_MOD;
                end
            end
            sqrb_pkg::S_MOD:
            begin
                if (seq_done && exp_done)
                begin
                    state_next = sqrb_pkg::S_DECIDE;
                end
            end
            sqrb_pkg::S_DECIDE:
            begin
                if (item_reg.action == sqrb_pkg::ACT_INSERT)
                begin
                    if (is_late || is_drop)
                    begin
                        if (out_free)
                        begin
                            state_next = sqrb_pkg::S_IDLE;
                        end
                    end
                    else if (is_eq)
                    begin
                        state_next = sqrb_pkg::S_DRAIN_RD;
                    end
                    else
                    begin
                        state_next = sqrb_pkg::S_BUF_RD;
                    end
                end
                else if (fire)
                begin
                    state_next = sqrb_pkg::S_SKIP_RD;
                end
                else if (out_free)
                begin
                    state_next = sqrb_pkg::S_IDLE;
                end
            end
            sqrb_pkg::S_BUF_RD:
            begin
                state_next = sqrb_pkg::S_BUF_CHK;
            end
            sqrb_pkg::S_BUF_CHK:
            begin
                if (out_free)
                begin
                    state_next = sqrb_pkg::S_IDLE;
                end
            end
            sqrb_pkg::S_SKIP_RD:
            begin
                state_next = skip_go ? sqrb_pkg::S_SKIP_CHK : sqrb_pkg::S_DRAIN_RD;
            end
            sqrb_pkg::S_SKIP_CHK:
            begin
                state_next = hit_exp ? sqrb_pkg::S_DRAIN_RD : sqrb_pkg::S_SKIP_RD;
            end
            sqrb_pkg::S_DRAIN_RD:
            begin
                state_next = sqrb_pkg::S_DRAIN_CHK;
            end
            sqrb_pkg::S_DRAIN_CHK:
            begin
                if (out_free)
                begin
                    state_next = drain_more ? sqrb_pkg::S_DRAIN_RD : sqrb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sqrb_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        item_next         = item_reg;
        exp_next          = exp_reg;
        exp_mod_next      = exp_mod_reg;
        highest_next      = highest_reg;
        gap_open_next     = gap_open_reg;
        gap_start_next    = gap_start_reg;
        ws_next           = ws_reg;
        max_wait_next     = max_wait_reg;
        skp_next          = skp_reg;
        cnt_next          = cnt_reg;
        pend_next         = pend_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        slot_cmd          = '0;
        slot_addr         = exp_mod_reg;

        if (cfg_valid)
        begin
            if (cfg_index == sqrb_pkg::REG_WINDOW_SIZE)
            begin
                ws_next = cfg_data[sqrb_pkg::WS_W-1:0];
            end
            else if (cfg_index == sqrb_pkg::REG_MAX_WAIT)
            begin
                max_wait_next = cfg_data;
            end
        end

        unique case (state_reg)
            sqrb_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = item;
                end
            end
            sqrb_pkg::S_MOD:
            begin
                if (seq_done && exp_done)
                begin
                    exp_mod_next = exp_rem;
                end
            end
            sqrb_pkg::S_DECIDE:
            begin
                if (item_reg.action == sqrb_pkg::ACT_INSERT)
                begin
                    if (is_late || is_drop)
                    begin
                        if (out_free)
                        begin
                            result_valid_next = 1'b1;
                            result_next = mk_result(is_late ? sqrb_pkg::KIND_LATE
                                                            : sqrb_pkg::KIND_DROP,
                                                    item_reg.seq, pay_m, '0, 1'b1);
                        end
                    end
                    else if (is_eq)
                    begin
                        pend_next     = mk_result(sqrb_pkg::KIND_RELEASED, item_reg.seq,
                                                  pay_m, '0, 1'b0);
                        exp_next      = exp_reg + 1'b1;
                        exp_mod_next  = exp_mod_inc;
                        gap_open_next = 1'b0;
                        cnt_next      = sqrb_pkg::CNT_W'(1);
                    end
                end
                else if (fire)
                begin
                    skp_next = '0;
                end
                else if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_next = mk_result(sqrb_pkg::KIND_NO_TIMEOUT, exp_reg,
                                            '0, '0, 1'b1);
                end
            end
            sqrb_pkg::S_BUF_RD:
            begin
            end
            sqrb_pkg::S_BUF_CHK:
            begin
                slot_addr = seq_rem;
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    if (hit_seq)
                    begin
                        result_next = mk_result(sqrb_pkg::KIND_DUPLICATE, item_reg.seq,
                                                pay_m, '0, 1'b1);
                    end
                    else
                    begin
                        result_next = mk_result(sqrb_pkg::KIND_BUFFERED, item_reg.seq,
                                                pay_m, '0, 1'b1);
                        slot_cmd.wr = 1'b1;
                        if (item_reg.seq > highest_reg)
                        begin
                            highest_next = item_reg.seq;
                        end
                        if (!gap_open_reg)
                        begin
                            gap_open_next  = 1'b1;
                            gap_start_next = item_reg.now;
                        end
                    end
                end
            end
            sqrb_pkg::S_SKIP_RD:
            begin
                if (!skip_go)
                begin
                    gap_open_next = 1'b0;
                    pend_next     = mk_result(sqrb_pkg::KIND_SKIPPED, exp_reg, '0,
                                              sqrb_pkg::SKIP_W'(skp_reg), 1'b0);
                    cnt_next      = sqrb_pkg::CNT_W'(1);
                end
            end
            sqrb_pkg::S_SKIP_CHK:
            begin
                if (hit_exp)
                begin
                    gap_open_next = 1'b0;
                    pend_next     = mk_result(sqrb_pkg::KIND_SKIPPED, exp_reg, '0,
                                              sqrb_pkg::SKIP_W'(skp_reg), 1'b0);
                    cnt_next      = sqrb_pkg::CNT_W'(1);
                end
                else
                begin
                    exp_next     = exp_reg + 1'b1;
                    exp_mod_next = exp_mod_inc;
                    skp_next     = skp_reg + 1'b1;
                end
            end
            sqrb_pkg::S_DRAIN_RD:
            begin
            end
            sqrb_pkg::S_DRAIN_CHK:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_next       = pend_reg;
                    result_next.last  = !drain_more;
                    if (drain_more)
                    begin
                        pend_next    = mk_result(sqrb_pkg::KIND_RELEASED, exp_reg,
                                                 sqrb_pkg::PAY_W'(rd_payload), '0, 1'b0);
                        slot_cmd.clr = 1'b1;
                        exp_next     = exp_reg + 1'b1;
                        exp_mod_next = exp_mod_inc;
                        cnt_next     = cnt_reg + 1'b1;
                    end
                    else if (hit_exp)
                    begin
                        // run cut at the result limit: reopen the gap
                        gap_open_next  = 1'b1;
                        gap_start_next = item_reg.now;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sqrb_pkg::S_IDLE;
            exp_reg          <= sqrb_pkg::SEQ_W'(1);
            exp_mod_reg      <= '0;
            highest_reg      <= '0;
            gap_open_reg     <= 1'b0;
            gap_start_reg    <= '0;
            ws_reg           <= sqrb_pkg::WS_RESET;
            max_wait_reg     <= sqrb_pkg::MAX_WAIT_RESET;
            skp_reg          <= '0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            exp_reg          <= exp_next;
            exp_mod_reg      <= exp_mod_next;
            highest_reg      <= highest_next;
            gap_open_reg     <= gap_open_next;
            gap_start_reg    <= gap_start_next;
            ws_reg           <= ws_next;
            max_wait_reg     <= max_wait_next;
            skp_reg          <= skp_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    assign item_stall   = (state_reg != sqrb_pkg::S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

endmodule

// ----- rtl/core/sqrb_checker.sv -----
// ----------------------------------------------------------------------------
// sqrb_checker
// Port-level checks on the reorder buffer, bound to the top level.
// ----------------------------------------------------------------------------
module sqrb_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            item_valid,
    input logic                            item_stall,
    input sqrb_pkg::in_item_t              item,
    input logic                            result_valid,
    input logic                            result_stall,
    input sqrb_pkg::out_item_t             result,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [sqrb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [sqrb_pkg::CFG_DATA_W-1:0] cfg_data
);

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item taken while previous item in progress");

    // more results still to come: no new item may enter
    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> item_stall)
        else $error("input open while a release run is in flight");

    a_single_kinds_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == sqrb_pkg::KIND_BUFFERED ||
                         result.kind == sqrb_pkg::KIND_LATE ||
                         result.kind == sqrb_pkg::KIND_DUPLICATE ||
                         result.kind == sqrb_pkg::KIND_DROP ||
                         result.kind == sqrb_pkg::KIND_NO_TIMEOUT) |-> result.last)
        else $error("single-result beat without last");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

endmodule

bind sequence_reorder_buffer sqrb_checker u_sqrb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
);

// ----- tb/sv/tb_sequence_reorder_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequence_reorder_buffer
// Self-checking bench for the sliding-window sequence reorder buffer.
// A behavioural copy of the buffer predicts every result beat from each
// accepted packet or timeout beat. Directed tests cover ordering, window
// bound, gap timer and register extremes. Randomised phases then run under
// several window and wait settings, with random idles on both sides.
// ----------------------------------------------------------------------------
module tb_sequence_reorder_buffer;
    import sqrb_pkg::*;

    localparam int WIN_MAX = 32;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    in_item_t              item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    out_item_t             result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [31:0] buf_seq [WIN_MAX];
    logic [31:0] buf_tag [WIN_MAX];
    logic        buf_full [WIN_MAX];
    logic [31:0] next_seq;
    logic [31:0] top_seq;
    logic        gap_live;
    logic [31:0] gap_t0;
    logic [5:0]  win_reg;
    logic [31:0] wait_lim;

    out_item_t   step_q [$];
    out_item_t   pending [$];
    logic [31:0] now_tick;
    int          idle_pct = 23;
    int          stall_pct = 23;
    int          errors = 0;
    int          n_items = 0;
    int          n_checked = 0;
    int          n_released = 0;
    int          n_skips = 0;

    sequence_reorder_buffer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void reset_buffer_model();
        foreach (buf_full[i])
        begin
            buf_full[i] = 1'b0;
            buf_seq[i]  = '0;
            buf_tag[i]  = '0;
        end
        next_seq = 32'd1;
        top_seq  = '0;
        gap_live = 1'b0;
        gap_t0   = '0;
        win_reg  = WS_RESET;
        wait_lim = MAX_WAIT_RESET;
    endfunction

    function automatic int unsigned live_window();
        return (win_reg == 0 || win_reg > WIN_MAX) ? WIN_MAX : win_reg;
    endfunction

    function automatic void add_result(kind_t k, logic [31:0] s, logic [31:0] p,
                                       logic [5:0] n);
        out_item_t r;
        r.kind        = k;
        r.out_seq     = s;
        r.out_payload = p;
        r.skipped     = n;
        r.last        = 1'b0;
        step_q.push_back(r);
        if (k == KIND_RELEASED)
            n_released++;
        if (k == KIND_SKIPPED)
            n_skips++;
    endfunction

    function automatic void release_run(logic [31:0] t);
        int unsigned w;
        int unsigned s;
        w = live_window();
        while (step_q.size() < RESULTS_MAX)
        begin
            s = next_seq % w;
            if (!buf_full[s] || buf_seq[s] != next_seq)
                return;
            add_result(KIND_RELEASED, next_seq, buf_tag[s], '0);
            buf_full[s] = 1'b0;
            next_seq++;
        end
        // run cut at the result bound: rearm the timer so the rest follows
        s = next_seq % w;
        if (buf_full[s] && buf_seq[s] == next_seq)
        begin
            gap_live = 1'b1;
            gap_t0   = t;
        end
    endfunction

    function automatic void predict_outcome(in_item_t it);
        int unsigned w;
        int unsigned s;
        logic [31:0] age;
        logic [63:0] bound;
        logic [5:0]  skp;
        w = live_window();
        step_q.delete();
        if (it.action == ACT_INSERT)
        begin
            bound = {32'd0, next_seq} + 64'(w) - 64'd1;
            if (it.seq < next_seq)
                add_result(KIND_LATE, it.seq, it.payload, '0);
            else if (it.seq == next_seq)
            begin
                add_result(KIND_RELEASED, it.seq, it.payload, '0);
                next_seq++;
                gap_live = 1'b0;
                release_run(it.now);
            end
            else if ({32'd0, it.seq} > bound)
                add_result(KIND_DROP, it.seq, it.payload, '0);
            else
            begin
                s = it.seq % w;
                if (buf_full[s] && buf_seq[s] == it.seq)
                    add_result(KIND_DUPLICATE, it.seq, it.payload, '0);
                else
                begin
                    buf_full[s] = 1'b1;
                    buf_seq[s]  = it.seq;
                    buf_tag[s]  = it.payload;
                    if (it.seq > top_seq)
                        top_seq = it.seq;
                    if (!gap_live)
                    begin
                        gap_live = 1'b1;
                        gap_t0   = it.now;
                    end
                    add_result(KIND_BUFFERED, it.seq, it.payload, '0);
                end
            end
        end
        else
        begin
            age = it.now - gap_t0;
            if (!gap_live || age < wait_lim)
                add_result(KIND_NO_TIMEOUT, next_seq, '0, '0);
            else
            begin
                skp = '0;
                while (next_seq <= top_seq && skp < WIN_MAX)
                begin
                    s = next_seq % w;
                    if (buf_full[s] && buf_seq[s] == next_seq)
                        break;
                    next_seq++;
                    skp++;
                end
                gap_live = 1'b0;
                add_result(KIND_SKIPPED, next_seq, '0, skp);
                release_run(it.now);
            end
        end
        step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i])
            pending.push_back(step_q[i]);
    endfunction

    task automatic send_item(logic act, logic [31:0] s, logic [31:0] p, logic [31:0] t);
        in_item_t it;
        int       gap;
        it.action  = act;
        it.seq     = s;
        it.payload = p;
        it.now     = t;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        predict_outcome(it);
        n_items++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data, logic more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (!more)
            cfg_valid <= 1'b0;
        case (idx)
            REG_WINDOW_SIZE: win_reg = data[5:0];
            REG_MAX_WAIT:    wait_lim = data;
            default: ;
        endcase
    endtask

    task automatic drain_outstanding();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending.size() != 0);
    endtask

    task automatic send_random();
        int unsigned w;
        int unsigned r;
        int unsigned s;
        logic        act;
        logic [31:0] sq;
        logic [31:0] t;
        w   = live_window();
        r   = $urandom_range(99);
        act = ACT_INSERT;
        sq  = next_seq;
        now_tick += $urandom_range(0, 12);
        t = now_tick;
        if (r < 8)
            sq = next_seq;
        else if (r < 55)
            sq = next_seq + $urandom_range(0, w - 1);
        else if (r < 62)
            sq = next_seq - $urandom_range(1, 3);
        else if (r < 68)
            sq = next_seq + w + $urandom_range(0, 3);
        else if (r < 74)
        begin
            s  = $urandom_range(0, w - 1);
            sq = buf_full[s] ? buf_seq[s] : next_seq + 1;
        end
        else if (r < 92)
        begin
            act = ACT_TIMEOUT;
            sq  = $urandom;
            if ($urandom_range(3) == 0)
                now_tick += $urandom_range(0, 80);
            t = now_tick;
        end
        else
        begin
            act = $urandom_range(1) ? ACT_TIMEOUT : ACT_INSERT;
            sq  = $urandom;
            t   = $urandom;
        end
        send_item(act, sq, $urandom, t);
    endtask

    task automatic test_ordering();
        send_item(ACT_INSERT, 32'd1, 32'hFFFF_FFFF, now_tick);
        send_item(ACT_INSERT, 32'd0, 32'd0, now_tick);
        send_item(ACT_INSERT, 32'd4, $urandom, now_tick);
        send_item(ACT_INSERT, 32'd4, $urandom, now_tick);
        send_item(ACT_INSERT, 32'd3, $urandom, now_tick);
        send_item(ACT_INSERT, 32'd2, $urandom, now_tick);
    endtask

    task automatic test_window_bound();
        now_tick += 3;
        send_item(ACT_INSERT, next_seq + 32, $urandom, now_tick);
        send_item(ACT_INSERT, next_seq + 31, $urandom, now_tick);
        send_item(ACT_INSERT, 32'hFFFF_FFFF, $urandom, now_tick);
    endtask

    task automatic test_gap_timeout();
        send_item(ACT_TIMEOUT, $urandom, $urandom, gap_t0 + 32'd10);
        send_item(ACT_TIMEOUT, $urandom, $urandom, gap_t0 + wait_lim);
        send_item(ACT_TIMEOUT, $urandom, $urandom, now_tick);
    endtask

    task automatic test_registers();
        drain_outstanding();
        write_reg(REG_WINDOW_SIZE, 32'd0, 1'b1);
        write_reg(REG_MAX_WAIT, 32'd0, 1'b1);
        write_reg(REG_SPARE_A, $urandom, 1'b1);
        write_reg(REG_SPARE_B, $urandom, 1'b0);
        send_item(ACT_INSERT, next_seq + 31, $urandom, now_tick);
        // shrinking the window strands the held packet; skip runs to its limit
        drain_outstanding();
        write_reg(REG_WINDOW_SIZE, 32'd5, 1'b0);
        send_item(ACT_TIMEOUT, $urandom, $urandom, now_tick);
        drain_outstanding();
        write_reg(REG_WINDOW_SIZE, 32'd1, 1'b0);
        send_item(ACT_INSERT, next_seq + 1, $urandom, now_tick);
        send_item(ACT_INSERT, next_seq, $urandom, now_tick);
        drain_outstanding();
        write_reg(REG_WINDOW_SIZE, 32'd63, 1'b1);
        write_reg(REG_MAX_WAIT, 32'hFFFF_FFFF, 1'b0);
        send_item(ACT_INSERT, next_seq + 2, $urandom, now_tick);
        send_item(ACT_TIMEOUT, $urandom, $urandom, now_tick + 32'd5);
        send_item(ACT_TIMEOUT, $urandom, $urandom, gap_t0 - 32'd1);
        drain_outstanding();
        write_reg(REG_WINDOW_SIZE, 32'd33, 1'b1);
        write_reg(REG_MAX_WAIT, 32'd1, 1'b0);
        now_tick += 7;
        send_item(ACT_INSERT, next_seq + 1, $urandom, now_tick);
        send_item(ACT_TIMEOUT, $urandom, $urandom, now_tick);
        send_item(ACT_TIMEOUT, $urandom, $urandom, now_tick + 32'd1);
    endtask

    task automatic test_random_traffic();
        logic [5:0]  phase_win [10];
        logic [31:0] phase_wait [10];
        phase_win  = '{6'd32, 6'd8, 6'd1, 6'd2, 6'd16, 6'd31, 6'd0, 6'd5, 6'd63, 6'd33};
        phase_wait = '{32'd40, 32'd20, 32'd5, 32'd0, 32'd500, 32'd1, 32'd30, 32'd60,
                       32'hFFFF_FFFF, 32'd25};
        for (int i = 0; i < 10; i++)
        begin
            drain_outstanding();
            write_reg(REG_WINDOW_SIZE, {26'd0, phase_win[i]}, 1'b1);
            write_reg(REG_MAX_WAIT, phase_wait[i], 1'b0);
            idle_pct  = (i == 6) ? 0 : 23;
            stall_pct = idle_pct;
            repeat (33) send_random();
        end
        idle_pct  = 23;
        stall_pct = 23;
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending.size() == 0)
            begin
                $error("unexpected result beat: kind %0d seq %0d", result.kind, result.out_seq);
                errors++;
            end
            else
            begin
                want = pending.pop_front();
                n_checked++;
                if (result.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, result.kind);
                    errors++;
                end
                if (result.out_seq !== want.out_seq)
                begin
                    $error("out_seq: expected %0d, got %0d", want.out_seq, result.out_seq);
                    errors++;
                end
                if (result.out_payload !== want.out_payload)
                begin
                    $error("out_payload: expected %h, got %h", want.out_payload,
                           result.out_payload);
                    errors++;
                end
                if (result.skipped !== want.skipped)
                begin
                    $error("skipped: expected %0d, got %0d", want.skipped, result.skipped);
                    errors++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, result.last);
                    errors++;
                end
            end
        end
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        now_tick = $urandom;
        reset_buffer_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_ordering();
        test_window_bound();
        test_gap_timeout();
        test_registers();
        test_random_traffic();
        drain_outstanding();
        repeat (40) @(posedge clk);
        if (pending.size() != 0)
        begin
            $error("%0d result beats never arrived", pending.size());
            errors++;
        end
        $display("Run covered %0d packet and timeout beats, %0d result beats checked,",
                 n_items, n_checked);
        $display("with %0d packets released and %0d timeout skips.", n_released, n_skips);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/sqrb_pkg.sv
rtl/core/sqrb_rem_unit.sv
rtl/core/sqrb_slot_store.sv
rtl/core/sequence_reorder_buffer.sv
rtl/core/sqrb_checker.sv
tb/sv/tb_sequence_reorder_buffer.sv
